@@ sv/acpi_ec_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the ACPI embedded controller host interface.
// Used by acpi_ec_host_interface_core and its checker; depends on nothing.
package acpi_ec_pkg;

  typedef enum logic [1:0] {
    CMD_HOST_READ  = 2'd0,
    CMD_HOST_WRITE = 2'd1,
    CMD_POST_EVENT = 2'd2
  } req_cmd_e;

  typedef enum logic {
    PORT_DATA   = 1'b0,
    PORT_STATUS = 1'b1
  } port_sel_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_RD_ADDR = 2'd1,
    PH_WR_ADDR = 2'd2,
    PH_WR_VAL  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    OC_OK       = 2'd0,
    OC_BAD_CMD  = 2'd1,
    OC_BAD_DATA = 2'd2,
    OC_Q_FULL   = 2'd3
  } outcome_e;

  localparam logic [7:0] EC_CMD_READ  = 8'h80;
  localparam logic [7:0] EC_CMD_WRITE = 8'h81;
  localparam logic [7:0] EC_CMD_QUERY = 8'h84;

  localparam int unsigned STS_OBF_BIT     = 0;
  localparam int unsigned STS_SCI_EVT_BIT = 5;

endpackage

@@ sv/acpi_ec_host_interface_core.sv @@
`timescale 1ns / 1ps
// Top level of the ACPI embedded controller host interface, device side.
// Depends on acpi_ec_pkg for command, phase and outcome codes.
//
// Usage: each input request is one host access to the data port (0x62) or
// the command/status port (0x66), or a query code posted by the controller.
// Requests use in_valid_i / in_stall_o, results use out_valid_o / out_stall_i;
// a transfer happens on a clock edge where valid is high and stall is low.
// Every request produces exactly one result in request order.
// On acceptance the request is registered along with the synchronous read
// of the controller space and query queue memories; the modify and
// write-back step then registers the result into the output register once
// that register is free. One request is in flight at a time, so a new
// request is taken only after the previous result has reached that register.
// The result sits in an output register, so the next request is accepted
// while a finished result waits; a stalled receiver holds the result and
// the in-flight request until the output register frees up.
// Reset clears the phase, output buffer, queue pointers and the per-byte
// valid flags, so the controller space reads as zero right after reset
// with no clearing pass.
module acpi_ec_host_interface_core #(
  parameter int unsigned QUERY_DEPTH = 8,
  parameter int unsigned SPACE_BYTES = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] cmd_i,
  input  logic       port_sel_i,
  input  logic [7:0] write_byte_i,
  input  logic [7:0] event_code_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_byte_o,
  output logic [1:0] outcome_o,
  output logic       event_pending_o
);

  localparam int unsigned AW = $clog2(SPACE_BYTES);
  localparam int unsigned QW = (QUERY_DEPTH > 1) ? $clog2(QUERY_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUERY_DEPTH + 1);

  logic [AW-1:0] mod_tbl [256];

  for (genvar g = 0; g < 256; g++) begin : g_mod
    assign mod_tbl[g] = AW'(g % SPACE_BYTES);
  end

  logic [7:0] space_mem [SPACE_BYTES];
  logic [7:0] query_mem [QUERY_DEPTH];
  logic [SPACE_BYTES-1:0] space_vld_q;

  logic       busy_q;
  logic [1:0] cmd_q;
  logic       port_q;
  logic [7:0] wbyte_q;
  logic [7:0] ecode_q;
  logic [7:0] sp_rdata_q;
  logic       sp_rvld_q;
  logic [7:0] q_rdata_q;

  acpi_ec_pkg::phase_e phase_q, phase_d;
  logic [7:0]    tgt_q, tgt_d;
  logic [7:0]    obyte_q, obyte_d;
  logic          obf_q, obf_d;
  logic [QW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;

  logic       out_valid_q;
  logic [7:0] rbyte_q, rbyte_d;
  logic [1:0] oc_q, oc_d;
  logic       evp_q;

  logic          accept;
  logic          finish;
  logic          sp_we;
  logic          q_we;
  logic [AW-1:0] sp_raddr;
  logic [AW-1:0] sp_waddr;
  logic [QW:0]   tail_sum;
  logic [QW-1:0] tail;
  logic          q_full;
  logic [7:0]    status;

  assign in_stall_o = busy_q;
  assign accept     = in_valid_i && !busy_q;
  assign finish     = busy_q && (!out_valid_q || !out_stall_i);

  assign sp_raddr = mod_tbl[write_byte_i];
  assign sp_waddr = mod_tbl[tgt_q];

  assign tail_sum = (QW + 1)'(head_q) + (QW + 1)'(count_q);
  assign tail     = (tail_sum >= (QW + 1)'(QUERY_DEPTH)) ?
                    QW'(tail_sum - (QW + 1)'(QUERY_DEPTH)) : QW'(tail_sum);
  assign q_full   = (count_q == CW'(QUERY_DEPTH));

  always_comb begin
    status = 8'h00;
    status[acpi_ec_pkg::STS_OBF_BIT]     = obf_q;
    status[acpi_ec_pkg::STS_SCI_EVT_BIT] = (count_q != '0);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sp_rdata_q <= space_mem[sp_raddr];
      q_rdata_q  <= query_mem[head_q];
    end
    if (sp_we) begin
      space_mem[sp_waddr] <= wbyte_q;
    end
    if (q_we) begin
      query_mem[tail] <= ecode_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_i;
      port_q  <= port_sel_i;
      wbyte_q <= write_byte_i;
      ecode_q <= event_code_i;
    end
    if (finish) begin
      rbyte_q <= rbyte_d;
      oc_q    <= oc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      sp_rvld_q   <= 1'b0;
      space_vld_q <= '0;
      phase_q     <= acpi_ec_pkg::PH_IDLE;
      tgt_q       <= 8'h00;
      obyte_q     <= 8'h00;
      obf_q       <= 1'b0;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      evp_q       <= 1'b0;
    end else begin
      if (accept) begin
        busy_q    <= 1'b1;
        sp_rvld_q <= space_vld_q[sp_raddr];
      end else if (finish) begin
        busy_q <= 1'b0;
      end
      if (sp_we) begin
        space_vld_q[sp_waddr] <= 1'b1;
      end
      phase_q <= phase_d;
      tgt_q   <= tgt_d;
      obyte_q <= obyte_d;
      obf_q   <= obf_d;
      head_q  <= head_d;
      count_q <= count_d;
      if (finish) begin
        out_valid_q <= 1'b1;
        evp_q       <= (count_d != '0);
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    phase_d = phase_q;
    tgt_d   = tgt_q;
    obyte_d = obyte_q;
    obf_d   = obf_q;
    head_d  = head_q;
    count_d = count_q;
    rbyte_d = 8'h00;
    oc_d    = acpi_ec_pkg::OC_OK;
    sp_we   = 1'b0;
    q_we    = 1'b0;
    if (finish) begin
      case (cmd_q)
        acpi_ec_pkg::CMD_HOST_READ: begin
          if (port_q == acpi_ec_pkg::PORT_STATUS) begin
            rbyte_d = status;
          end else begin
            rbyte_d = obyte_q;
            obf_d   = 1'b0;
          end
        end
        acpi_ec_pkg::CMD_HOST_WRITE: begin
          if (port_q == acpi_ec_pkg::PORT_STATUS) begin
            phase_d = acpi_ec_pkg::PH_IDLE;
            case (wbyte_q)
              acpi_ec_pkg::EC_CMD_READ: begin
                phase_d = acpi_ec_pkg::PH_RD_ADDR;
              end
              acpi_ec_pkg::EC_CMD_WRITE: begin
                phase_d = acpi_ec_pkg::PH_WR_ADDR;
              end
              acpi_ec_pkg::EC_CMD_QUERY: begin
                obf_d = 1'b1;
                if (count_q != '0) begin
                  obyte_d = q_rdata_q;
                  head_d  = (head_q == QW'(QUERY_DEPTH - 1)) ? '0 : QW'(head_q + 1'b1);
                  count_d = CW'(count_q - 1'b1);
                end else begin
                  obyte_d = 8'h00;
                end
              end
              default: begin
                oc_d = acpi_ec_pkg::OC_BAD_CMD;
              end
            endcase
          end else begin
            case (phase_q)
              acpi_ec_pkg::PH_RD_ADDR: begin
                obyte_d = sp_rvld_q ? sp_rdata_q : 8'h00;
                obf_d   = 1'b1;
                phase_d = acpi_ec_pkg::PH_IDLE;
              end
              acpi_ec_pkg::PH_WR_ADDR: begin
                tgt_d   = wbyte_q;
                phase_d = acpi_ec_pkg::PH_WR_VAL;
              end
              acpi_ec_pkg::PH_WR_VAL: begin
                sp_we   = 1'b1;
                phase_d = acpi_ec_pkg::PH_IDLE;
              end
              default: begin
                oc_d = acpi_ec_pkg::OC_BAD_DATA;
              end
            endcase
          end
        end
        acpi_ec_pkg::CMD_POST_EVENT: begin
          if (ecode_q != 8'h00) begin
            if (q_full) begin
              oc_d = acpi_ec_pkg::OC_Q_FULL;
            end else begin
              q_we    = 1'b1;
              count_d = CW'(count_q + 1'b1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_byte_o     = rbyte_q;
  assign outcome_o       = oc_q;
  assign event_pending_o = evp_q;

endmodule

@@ sv/acpi_ec_chk.sv @@
`timescale 1ns / 1ps
// Port-level checker for acpi_ec_host_interface_core, bound to the top level.
// Depends on acpi_ec_pkg for the outcome codes.
module acpi_ec_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] read_byte_o,
  input logic [1:0] outcome_o,
  input logic       event_pending_o
);

  // A stalled result must hold until the receiver takes it.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_byte_o) &&
    $stable(outcome_o) && $stable(event_pending_o))
    else $error("stalled result changed");

  // Only one request is worked on at a time.
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while another is in flight");

  // A dropped event means the queue is full, so an event is pending.
  a_full_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outcome_o == acpi_ec_pkg::OC_Q_FULL |-> event_pending_o)
    else $error("queue full reported without a pending event");

  // Error outcomes come from writes or posts, which never return data.
  a_err_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outcome_o != acpi_ec_pkg::OC_OK |-> read_byte_o == 8'h00)
    else $error("error outcome returned read data");

endmodule

bind acpi_ec_host_interface_core acpi_ec_chk u_acpi_ec_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .read_byte_o     (read_byte_o),
  .outcome_o       (outcome_o),
  .event_pending_o (event_pending_o)
);
